// ----- src/pbr_pkg.sv -----
// Shared types and constants for the particle boundary router.
// Field widths, side mode codes, direction and action codes, register indexes.
// No dependencies.
`default_nettype none
package pbr_pkg;

  localparam int POS_W   = 28;
  localparam int MOM_W   = 32;
  localparam int CELLS_W = 11;
  localparam int MODES_W = 6;
  localparam int SLOT_W  = 16;
  localparam int DIR_W   = 2;
  localparam int ACT_W   = 2;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 3;

  localparam logic [MODE_W-1:0] MODE_WRAP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REFLECT = 2'd1;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;

  localparam logic [ACT_W-1:0] ACT_KEEP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DROP = 2'd2;

  localparam logic [IDX_W-1:0] REG_CELLS_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CELLS_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_CELLS_Z    = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOW_MODES  = 3'd3;
  localparam logic [IDX_W-1:0] REG_HIGH_MODES = 3'd4;

  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic             drop;
  } axis_flags_t;

endpackage
`default_nettype wire

// ----- src/particle_boundary_router.sv -----
// Top level of the particle boundary router: config registers, input and result registers.
// Depends on pbr_pkg and pbr_axis.
`default_nettype none
// One particle is accepted per cycle while in_ready is high. It is held in the input register,
// and its result is loaded into the result register and held there until taken; sustained rate
// is one item per clock while out_ready stays high. The only state carried from
// item to item is the kept slot counter, updated as an item moves into the result
// register. Per-axis checks are combinational compares and adds between the input and
// result registers. A stalled output backs up through both registers before in_ready
// drops. Configuration registers are written with cfg_we and take effect on the next
// item; write them only while the block holds no items.
module particle_boundary_router import pbr_pkg::*; #(
  parameter int MAX_CELLS      = 1024,
  parameter int FRAC_BITS      = 16,
  parameter int PATCH_CAPACITY = 65536
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic        [IDX_W-1:0]   cfg_index,
  input  wire logic        [CELLS_W-1:0] cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [POS_W-1:0]   pos_x,
  input  wire logic signed [POS_W-1:0]   pos_y,
  input  wire logic signed [POS_W-1:0]   pos_z,
  input  wire logic signed [MOM_W-1:0]   mom_x,
  input  wire logic signed [MOM_W-1:0]   mom_y,
  input  wire logic signed [MOM_W-1:0]   mom_z,
  input  wire logic                      start_of_patch,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed      [POS_W-1:0]   new_pos_x,
  output logic signed      [POS_W-1:0]   new_pos_y,
  output logic signed      [POS_W-1:0]   new_pos_z,
  output logic signed      [MOM_W-1:0]   new_mom_x,
  output logic signed      [MOM_W-1:0]   new_mom_y,
  output logic signed      [MOM_W-1:0]   new_mom_z,
  output logic signed      [DIR_W-1:0]   dir_x,
  output logic signed      [DIR_W-1:0]   dir_y,
  output logic signed      [DIR_W-1:0]   dir_z,
  output logic             [ACT_W-1:0]   action,
  output logic             [SLOT_W-1:0]  local_slot
);

  localparam int SLOT_SPAN = 1 << SLOT_W;
  localparam int SLOT_LIMIT_I =
    ((PATCH_CAPACITY < SLOT_SPAN) ? PATCH_CAPACITY : SLOT_SPAN) - 1;
  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(SLOT_LIMIT_I);

  logic        [CELLS_W-1:0] cells [3];
  logic        [MODES_W-1:0] low_side_modes;
  logic        [MODES_W-1:0] high_side_modes;
  logic        [SLOT_W-1:0]  kept_count;
  logic        [SLOT_W-1:0]  kept_count_next;

  logic                      s1_valid;
  logic signed [POS_W-1:0]   s1_pos [3];
  logic signed [MOM_W-1:0]   s1_mom [3];
  logic                      s1_start;

  logic signed [POS_W-1:0]   ax_pos [3];
  logic signed [MOM_W-1:0]   ax_mom [3];
  axis_flags_t               ax_flags [3];

  logic signed [POS_W-1:0]   out_pos [3];
  logic signed [MOM_W-1:0]   out_mom [3];
  logic signed [DIR_W-1:0]   out_dir [3];

  logic                      advance;
  logic                      any_drop;
  logic                      all_still;
  logic        [ACT_W-1:0]   action_next;
  logic        [SLOT_W-1:0]  slot_base;
  logic        [SLOT_W-1:0]  slot_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells[0]        <= CELLS_W'(1);
      cells[1]        <= CELLS_W'(1);
      cells[2]        <= CELLS_W'(1);
      low_side_modes  <= '0;
      high_side_modes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELLS_X:    cells[0]        <= cfg_data;
        REG_CELLS_Y:    cells[1]        <= cfg_data;
        REG_CELLS_Z:    cells[2]        <= cfg_data;
        REG_LOW_MODES:  low_side_modes  <= cfg_data[MODES_W-1:0];
        REG_HIGH_MODES: high_side_modes <= cfg_data[MODES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_pos[0] <= pos_x;
      s1_pos[1] <= pos_y;
      s1_pos[2] <= pos_z;
      s1_mom[0] <= mom_x;
      s1_mom[1] <= mom_y;
      s1_mom[2] <= mom_z;
      s1_start  <= start_of_patch;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    pbr_axis #(
      .MAX_CELLS (MAX_CELLS),
      .FRAC_BITS (FRAC_BITS)
    ) u_axis (
      .pos     (s1_pos[i]),
      .mom     (s1_mom[i]),
      .cells   (cells[i]),
      .lo_mode (low_side_modes[2*i +: MODE_W]),
      .hi_mode (high_side_modes[2*i +: MODE_W]),
      .new_pos (ax_pos[i]),
      .new_mom (ax_mom[i]),
      .flags   (ax_flags[i])
    );
  end

  always_comb begin
    any_drop  = ax_flags[0].drop || ax_flags[1].drop || ax_flags[2].drop;
    all_still = (ax_flags[0].dir == DIR_NONE) && (ax_flags[1].dir == DIR_NONE) &&
                (ax_flags[2].dir == DIR_NONE);
    slot_base = s1_start ? '0 : kept_count;
    slot_next = '0;
    kept_count_next = slot_base;
    if (any_drop) begin
      action_next = ACT_DROP;
    end else if (all_still) begin
      action_next = ACT_KEEP;
      slot_next   = slot_base;
      if (slot_base < SLOT_LIMIT) begin
        kept_count_next = slot_base + SLOT_W'(1);
      end
    end else begin
      action_next = ACT_SEND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      kept_count <= '0;
    end else begin
      if (advance) begin
        out_valid  <= 1'b1;
        kept_count <= kept_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        out_pos[i] <= ax_pos[i];
        out_mom[i] <= ax_mom[i];
        out_dir[i] <= ax_flags[i].dir;
      end
      action     <= action_next;
      local_slot <= slot_next;
    end
  end

  assign new_pos_x = out_pos[0];
  assign new_pos_y = out_pos[1];
  assign new_pos_z = out_pos[2];
  assign new_mom_x = out_mom[0];
  assign new_mom_y = out_mom[1];
  assign new_mom_z = out_mom[2];
  assign dir_x     = out_dir[0];
  assign dir_y     = out_dir[1];
  assign dir_z     = out_dir[2];

`ifndef ASSERT_OFF
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    kept_count <= SLOT_LIMIT)
    else $error("kept slot counter above limit");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_KEEP) |-> local_slot == '0)
    else $error("slot given to a particle that is not kept");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance && (action_next == ACT_KEEP) && (slot_base < SLOT_LIMIT)
    |=> kept_count == $past(slot_base) + SLOT_W'(1))
    else $error("kept slot counter did not advance");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && (action == $past(action_next)))
    else $error("result register missed a transfer");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");
`endif

endmodule
`default_nettype wire

// ----- src/pbr_axis.sv -----
// One axis of the boundary check: crossing test, wrap, reflect or absorb.
// Purely combinational; depends on pbr_pkg.
`default_nettype none
module pbr_axis import pbr_pkg::*; #(
  parameter int MAX_CELLS = 1024,
  parameter int FRAC_BITS = 16
) (
  input  wire logic signed [POS_W-1:0]   pos,
  input  wire logic signed [MOM_W-1:0]   mom,
  input  wire logic        [CELLS_W-1:0] cells,
  input  wire logic        [MODE_W-1:0]  lo_mode,
  input  wire logic        [MODE_W-1:0]  hi_mode,
  output logic signed      [POS_W-1:0]   new_pos,
  output logic signed      [MOM_W-1:0]   new_mom,
  output axis_flags_t                    flags
);

  localparam int W = ((CELLS_W + FRAC_BITS > POS_W) ? CELLS_W + FRAC_BITS : POS_W) + 3;
  localparam int CELLS_TOP = (1 << CELLS_W) - 1;
  localparam logic [CELLS_W-1:0] CELLS_MAX =
    (MAX_CELLS > CELLS_TOP) ? CELLS_W'(CELLS_TOP) : CELLS_W'(MAX_CELLS);
  localparam logic signed [W-1:0] POS_MAX_W = W'((64'sd1 <<< (POS_W - 1)) - 1);
  localparam logic signed [W-1:0] POS_MIN_W = -(W'(64'sd1 <<< (POS_W - 1)));
  localparam logic signed [MOM_W-1:0] MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};
  localparam logic signed [MOM_W-1:0] MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};

  function automatic logic signed [POS_W-1:0] sat(input logic signed [W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX_W) begin
      r = POS_MAX_W[POS_W-1:0];
    end else if (v < POS_MIN_W) begin
      r = POS_MIN_W[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] ext(input logic signed [POS_W-1:0] v);
    return {{(W-POS_W){v[POS_W-1]}}, v};
  endfunction

  logic        [CELLS_W-1:0] ce;
  logic signed [W-1:0]       pe;
  logic signed [W-1:0]       len;
  logic                      low_cross;
  logic                      high_cross;
  logic signed [POS_W-1:0]   wrap_lo;
  logic signed [POS_W-1:0]   wrap_hi;
  logic signed [POS_W-1:0]   mir_lo;
  logic signed [POS_W-1:0]   mir_hi;
  logic                      wrap_lo_over;
  logic                      mir_hi_edge;
  logic signed [MOM_W-1:0]   mom_neg;

  always_comb begin
    if (cells == '0) begin
      ce = CELLS_W'(1);
    end else if (cells > CELLS_MAX) begin
      ce = CELLS_MAX;
    end else begin
      ce = cells;
    end
  end

  assign pe  = ext(pos);
  assign len = signed'({{(W-CELLS_W-FRAC_BITS){1'b0}}, ce, {FRAC_BITS{1'b0}}});

  assign low_cross  = pe[W-1];
  assign high_cross = !pe[W-1] && (pe >= len);

  assign wrap_lo      = sat(pe + len);
  assign wrap_lo_over = ext(wrap_lo) >= len;
  assign wrap_hi      = sat(pe - len);
  assign mir_lo       = sat(-pe);
  assign mir_hi       = sat((len <<< 1) - pe);
  assign mir_hi_edge  = ext(mir_hi) >= len;
  assign mom_neg      = (mom == MOM_MIN) ? MOM_MAX : -mom;

  always_comb begin
    new_pos    = pos;
    new_mom    = mom;
    flags.dir  = DIR_NONE;
    flags.drop = 1'b0;
    if (low_cross) begin
      case (lo_mode)
        MODE_WRAP: begin
          if (wrap_lo_over) begin
            new_pos = '0;
          end else begin
            new_pos   = wrap_lo;
            flags.dir = DIR_NEG;
          end
        end
        MODE_REFLECT: begin
          new_pos = mir_lo;
          new_mom = mom_neg;
        end
        default: begin
          flags.drop = 1'b1;
        end
      endcase
    end else if (high_cross) begin
      case (hi_mode)
        MODE_WRAP: begin
          new_pos   = wrap_hi[POS_W-1] ? '0 : wrap_hi;
          flags.dir = DIR_POS;
        end
        MODE_REFLECT: begin
          new_pos = mir_hi_edge ? mir_hi - POS_W'(1) : mir_hi;
          new_mom = mom_neg;
        end
        default: begin
          flags.drop = 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
